### rtl/escape_time_fractal_iterator_core_assert.svh
// Assertion macros for the escape-time iterator core.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define ETFI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ETFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, always on (for reset behavior).
`define ETFI_ASSERT_RST_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/etfi_pkg.sv
package etfi_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 28;
    localparam int ITER_BITS    = 23;
    localparam int TRAP_BITS    = 31;
    localparam int CFG_IDX_BITS = 2;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [ITER_BITS-1:0]        t_iter;
    typedef logic [TRAP_BITS-1:0]        t_trap;

    localparam t_trap TRAP_NONE      = '1;
    localparam t_trap TRAP_MAX       = {{(TRAP_BITS-1){1'b1}}, 1'b0};
    localparam t_iter MAX_ITER_RESET = t_iter'(100);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE,
        CFG_C_REAL,
        CFG_C_IMAG,
        CFG_MAX_ITER
    } t_cfg_idx;

    typedef struct packed {
        t_word z_real;
        t_word z_imag;
        t_word c_real;
        t_word c_imag;
        t_iter max_iter;
    } t_job;

    typedef struct packed {
        logic  escaped;
        t_iter escape_index;
        t_word final_real;
        t_word final_imag;
        t_trap min_sq;
    } t_result;

endpackage

### rtl/etfi_fifo.sv
module etfi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/etfi_front.sv
module etfi_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [etfi_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  etfi_pkg::t_word                     i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  etfi_pkg::t_word                     i_point_real,
    input  etfi_pkg::t_word                     i_point_imag,
    output logic                                o_job_push,
    input  logic                                i_job_full,
    output etfi_pkg::t_job                      o_job
);

    import etfi_pkg::*;

    logic  r_mode;
    t_word r_c_real;
    t_word r_c_imag;
    t_iter r_max_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b1;
            r_c_real   <= '0;
            r_c_imag   <= '0;
            r_max_iter <= MAX_ITER_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_C_REAL:   r_c_real   <= i_cfg_data;
                CFG_C_IMAG:   r_c_imag   <= i_cfg_data;
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[ITER_BITS-1:0];
            endcase
        end
    end

    // Mandelbrot: z0 = 0, c = point. Julia: z0 = point, c = constant.
    assign o_job_push     = i_push && !i_job_full;
    assign o_full         = i_job_full;
    assign o_job.z_real   = r_mode ? '0 : i_point_real;
    assign o_job.z_imag   = r_mode ? '0 : i_point_imag;
    assign o_job.c_real   = r_mode ? i_point_real : r_c_real;
    assign o_job.c_imag   = r_mode ? i_point_imag : r_c_imag;
    assign o_job.max_iter = r_max_iter;

endmodule

### rtl/etfi_iter.sv
module etfi_iter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    input  etfi_pkg::t_job    i_job,
    output logic              o_res_push,
    input  logic              i_res_full,
    output etfi_pkg::t_result o_res
);

    import etfi_pkg::*;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int RE_BITS   = SUM_BITS - FRAC_BITS;
    localparam int IM_BITS   = PROD_BITS - FRAC_BITS + 1;
    localparam int NEXT_BITS = SUM_BITS - FRAC_BITS + 1;
    localparam int MSH_BITS  = PROD_BITS - FRAC_BITS;
    localparam logic [PROD_BITS-1:0] THRESH = PROD_BITS'(1) << (2 * FRAC_BITS + 2);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state                       r_state;
    t_word                        r_z_real;
    t_word                        r_z_imag;
    t_word                        r_c_real;
    t_word                        r_c_imag;
    t_iter                        r_max_iter;
    t_iter                        r_count;
    logic signed [PROD_BITS-1:0]  r_rr;
    logic signed [PROD_BITS-1:0]  r_ii;
    logic signed [PROD_BITS-1:0]  r_ri;
    logic                         r_escaped;
    t_iter                        r_index;
    t_trap                        r_trap;

    logic signed [SUM_BITS-1:0]   diff;
    logic signed [RE_BITS-1:0]    re_sh;
    logic signed [IM_BITS-1:0]    im_sh;
    logic signed [NEXT_BITS-1:0]  re_sum;
    logic signed [NEXT_BITS-1:0]  im_sum;
    t_word                        n_z_real;
    t_word                        n_z_imag;
    logic [PROD_BITS-1:0]         mag;
    logic [MSH_BITS-1:0]          mag_sh;
    t_trap                        trap_d;
    logic                         is_escape;

    function automatic t_word sat_word(input logic signed [NEXT_BITS-1:0] v);
        t_word res;
        if (!v[NEXT_BITS-1] && (|v[NEXT_BITS-2:WORD_BITS-1])) begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (v[NEXT_BITS-1] && !(&v[NEXT_BITS-2:WORD_BITS-1])) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = v[WORD_BITS-1:0];
        end
        return res;
    endfunction

    // Next z from the registered products, floor shift then saturate.
    assign diff     = SUM_BITS'(r_rr) - SUM_BITS'(r_ii);
    assign re_sh    = diff[SUM_BITS-1:FRAC_BITS];
    assign im_sh    = r_ri[PROD_BITS-1:FRAC_BITS-1];
    assign re_sum   = NEXT_BITS'(re_sh) + NEXT_BITS'(r_c_real);
    assign im_sum   = NEXT_BITS'(im_sh) + NEXT_BITS'(r_c_imag);
    assign n_z_real = sat_word(re_sum);
    assign n_z_imag = sat_word(im_sum);

    // |z|^2 of the current iterate reuses its squares.
    assign mag       = $unsigned(r_rr) + $unsigned(r_ii);
    assign mag_sh    = mag[PROD_BITS-1:FRAC_BITS];
    assign trap_d    = ((|mag_sh[MSH_BITS-1:TRAP_BITS]) || (mag_sh[TRAP_BITS-1:0] > TRAP_MAX))
                       ? TRAP_MAX : mag_sh[TRAP_BITS-1:0];
    assign is_escape = (r_count != '0) && (mag > THRESH);

    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign o_res_push = (r_state == S_DONE);

    assign o_res.escaped      = r_escaped;
    assign o_res.escape_index = r_index;
    assign o_res.final_real   = r_z_real;
    assign o_res.final_imag   = r_z_imag;
    assign o_res.min_sq       = r_trap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_z_real   <= i_job.z_real;
                        r_z_imag   <= i_job.z_imag;
                        r_c_real   <= i_job.c_real;
                        r_c_imag   <= i_job.c_imag;
                        r_max_iter <= i_job.max_iter;
                        r_count    <= '0;
                        r_trap     <= TRAP_NONE;
                        r_escaped  <= 1'b0;
                        r_index    <= '0;
                        r_state    <= (i_job.max_iter == '0) ? S_DONE : S_MUL;
                    end
                end
                S_MUL: begin
                    r_rr    <= r_z_real * r_z_real;
                    r_ii    <= r_z_imag * r_z_imag;
                    r_ri    <= r_z_real * r_z_imag;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (is_escape) begin
                        r_escaped <= 1'b1;
                        r_index   <= r_count - 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        if ((r_count != '0) && (trap_d < r_trap)) begin
                            r_trap <= trap_d;
                        end
                        if (r_count == r_max_iter) begin
                            r_state <= S_DONE;
                        end else begin
                            r_z_real <= n_z_real;
                            r_z_imag <= n_z_imag;
                            r_count  <= r_count + 1'b1;
                            r_state  <= S_MUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/escape_time_fractal_iterator_core.sv
// Escape-time iterator core. Each iteration squares, then adds and saturates.
// The iterator works on one item at a time; queued items wait until it returns to idle.
// A zero limit skips the iteration and yields a result directly.
// Reset (synchronous, active low) empties both queues, idles the iterator and loads
// register defaults: Mandelbrot mode, constant 0, limit 100.
module escape_time_fractal_iterator_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [etfi_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  etfi_pkg::t_word                   i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  etfi_pkg::t_word                   i_point_real,
    input  etfi_pkg::t_word                   i_point_imag,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_escaped,
    output etfi_pkg::t_iter                   o_escape_index,
    output etfi_pkg::t_word                   o_final_real,
    output etfi_pkg::t_word                   o_final_imag,
    output etfi_pkg::t_trap                   o_min_sq_distance
);

    import etfi_pkg::*;

    t_job    job_in;
    t_job    job_out;
    logic    job_push;
    logic    job_full;
    logic    job_empty;
    logic    job_pop;
    t_result res_in;
    t_result res_out;
    logic    res_push;
    logic    res_full;

    etfi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_point_real (i_point_real),
        .i_point_imag (i_point_imag),
        .o_job_push   (job_push),
        .i_job_full   (job_full),
        .o_job        (job_in)
    );

    etfi_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    etfi_iter u_iter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    etfi_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_escaped         = res_out.escaped;
    assign o_escape_index    = res_out.escape_index;
    assign o_final_real      = res_out.final_real;
    assign o_final_imag      = res_out.final_imag;
    assign o_min_sq_distance = res_out.min_sq;

endmodule

### rtl/etfi_checker.sv
`include "escape_time_fractal_iterator_core_assert.svh"

module etfi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic                              o_escaped,
    input etfi_pkg::t_iter                   o_escape_index,
    input etfi_pkg::t_word                   o_final_real,
    input etfi_pkg::t_word                   o_final_imag,
    input etfi_pkg::t_trap                   o_min_sq_distance
);

    import etfi_pkg::*;

    `ETFI_ASSERT_RST_NEXT(a_reset_clears, i_clk, !i_rst_n, empty && !full, "queues not cleared by reset")

    `ETFI_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_escaped) && $stable(o_escape_index) && $stable(o_final_real) && $stable(o_final_imag) && $stable(o_min_sq_distance), "waiting result changed")

    `ETFI_ASSERT_IMPLY(a_index_needs_escape, i_clk, i_rst_n, !empty && !o_escaped, o_escape_index == '0, "escape index without escape")

    `ETFI_ASSERT_IMPLY(a_first_escape_no_trap, i_clk, i_rst_n, !empty && o_escaped && (o_escape_index == '0), o_min_sq_distance == TRAP_NONE, "trap recorded before first iterate")

endmodule

bind escape_time_fractal_iterator_core etfi_checker u_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_escaped         (o_escaped),
    .o_escape_index    (o_escape_index),
    .o_final_real      (o_final_real),
    .o_final_imag      (o_final_imag),
    .o_min_sq_distance (o_min_sq_distance)
);

### tb/sv/tb_escape_time_fractal_iterator_core.sv
`timescale 1ns / 100ps

module tb_escape_time_fractal_iterator_core;

    import etfi_pkg::*;

    typedef struct packed {
        t_word re;
        t_word im;
    } t_point;

    localparam logic signed [65:0] ESC_LIMIT = 66'sh1 << (2 * FRAC_BITS + 2);
    localparam logic signed [65:0] W_HI      = 66'sh7FFF_FFFF;
    localparam logic signed [65:0] W_LO      = -66'sh8000_0000;
    localparam int                 SPAN      = 32'h2400_0000;

    localparam t_word PRESET_RE [4] = '{-32'sd214748365, 32'sd76504105,
                                        -32'sd107374182, -32'sd188377266};
    localparam t_word PRESET_IM [4] = '{32'sd41875931, 32'sd2684355,
                                        32'sd161061274, -32'sd103132902};

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [1:0] i_cfg_idx    = '0;
    t_word      i_cfg_data   = '0;
    logic       push         = 1'b0;
    t_word      i_point_real = '0;
    t_word      i_point_imag = '0;
    logic       pop          = 1'b0;
    logic       full;
    logic       empty;
    logic       o_escaped;
    t_iter      o_escape_index;
    t_word      o_final_real;
    t_word      o_final_imag;
    t_trap      o_min_sq_distance;

    // register shadow
    logic  mode_mandel = 1'b1;
    t_word jc_re       = '0;
    t_word jc_im       = '0;
    t_iter iter_limit  = MAX_ITER_RESET;

    t_point  point_queue [$];
    t_result due_results [$];
    int      points_taken = 0;
    int      points_acked = 0;
    int      results_seen = 0;
    int      mismatches   = 0;
    bit      quiet        = 1'b0;
    int      hold_left    = 0;
    bit      hold_done    = 1'b0;

    escape_time_fractal_iterator_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_point_real     (i_point_real),
        .i_point_imag     (i_point_imag),
        .empty            (empty),
        .pop              (pop),
        .o_escaped        (o_escaped),
        .o_escape_index   (o_escape_index),
        .o_final_real     (o_final_real),
        .o_final_imag     (o_final_imag),
        .o_min_sq_distance(o_min_sq_distance)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_word clamp_word(logic signed [65:0] v);
        if (v > W_HI) begin
            return 32'h7FFF_FFFF;
        end
        if (v < W_LO) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_result orbit_of(t_word p_re, t_word p_im);
        logic signed [65:0] zr, zi, cr, ci, rr, ii, ri, mag;
        logic [65:0]        trap_val;
        t_word              sr, si;
        t_result            res;
        res.escaped      = 1'b0;
        res.escape_index = '0;
        res.min_sq       = TRAP_NONE;
        if (mode_mandel) begin
            sr = '0;
            si = '0;
            cr = p_re;
            ci = p_im;
        end else begin
            sr = p_re;
            si = p_im;
            cr = jc_re;
            ci = jc_im;
        end
        for (int unsigned n = 0; n < iter_limit; n++) begin
            zr = sr;
            zi = si;
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            sr = clamp_word(((rr - ii) >>> FRAC_BITS) + cr);
            si = clamp_word((ri >>> (FRAC_BITS - 1)) + ci);
            zr = sr;
            zi = si;
            mag = zr * zr + zi * zi;
            if (mag > ESC_LIMIT) begin
                res.escaped      = 1'b1;
                res.escape_index = t_iter'(n);
                break;
            end
            trap_val = mag >>> FRAC_BITS;
            if (trap_val > TRAP_MAX) begin
                trap_val = TRAP_MAX;
            end
            if (t_trap'(trap_val) < res.min_sq) begin
                res.min_sq = t_trap'(trap_val);
            end
        end
        res.final_real = sr;
        res.final_imag = si;
        return res;
    endfunction

    // mostly the interesting region, some tiny values, some anything
    function automatic t_word pick_coord();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1: begin
                return t_word'($urandom);
            end
            2: begin
                return t_word'(int'($urandom_range(0, 2 ** 27)) - 2 ** 26);
            end
            default: begin
                return t_word'(int'($urandom_range(0, 2 * SPAN)) - SPAN);
            end
        endcase
    endfunction

    // |value| at least 2.125: escapes on the first step in Mandelbrot mode
    function automatic t_word far_coord();
        int mag;
        mag = int'($urandom_range(32'h2200_0000, 32'h7FFF_FFFF));
        return $urandom_range(1) ? t_word'(mag) : t_word'(-mag);
    endfunction

    // input side transfer
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            due_results.push_back(orbit_of(i_point_real, i_point_imag));
            void'(point_queue.pop_front());
            points_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || points_taken != points_acked) begin
            points_acked = points_taken;
            if (point_queue.size() != 0 && (quiet || $urandom_range(99) >= 32)) begin
                push         <= 1'b1;
                i_point_real <= point_queue[0].re;
                i_point_imag <= point_queue[0].im;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side; one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (!hold_done && results_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = 3000;
            pop <= 1'b0;
        end else begin
            pop <= quiet || $urandom_range(99) >= 32;
        end
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && pop && !empty) begin
            results_seen++;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: esc=%0d idx=%0d re=%h im=%h trap=%h",
                             o_escaped, o_escape_index, o_final_real, o_final_imag,
                             o_min_sq_distance);
                end
            end else begin
                exp_r = due_results.pop_front();
                if (o_escaped !== exp_r.escaped || o_escape_index !== exp_r.escape_index ||
                    o_final_real !== exp_r.final_real ||
                    o_final_imag !== exp_r.final_imag ||
                    o_min_sq_distance !== exp_r.min_sq) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  exp: esc=%0d idx=%0d re=%h im=%h trap=%h",
                                 exp_r.escaped, exp_r.escape_index, exp_r.final_real,
                                 exp_r.final_imag, exp_r.min_sq);
                        $display("  got: esc=%0d idx=%0d re=%h im=%h trap=%h",
                                 o_escaped, o_escape_index, o_final_real, o_final_imag,
                                 o_min_sq_distance);
                    end
                end
            end
        end
    end

    task automatic drain();
        while (point_queue.size() != 0 || due_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, t_word data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODE:     mode_mandel = data[0];
            CFG_C_REAL:   jc_re       = data;
            CFG_C_IMAG:   jc_im       = data;
            CFG_MAX_ITER: iter_limit  = data[ITER_BITS-1:0];
            default:      ;
        endcase
    endtask

    // unused upper bits of mode and limit carry random junk
    task automatic configure(logic m, t_word cre, t_word cim, t_iter lim);
        drain();
        write_reg(CFG_MODE, (t_word'($urandom) & ~t_word'(1)) | t_word'(m));
        write_reg(CFG_C_REAL, cre);
        write_reg(CFG_C_IMAG, cim);
        write_reg(CFG_MAX_ITER, (t_word'($urandom) << ITER_BITS) | t_word'(lim));
    endtask

    task automatic add_point(t_word re, t_word im);
        t_point p;
        p.re = re;
        p.im = im;
        point_queue.push_back(p);
    endtask

    task automatic queue_points(int count, bit far);
        t_point p;
        for (int k = 0; k < count; k++) begin
            p.re = far ? far_coord() : pick_coord();
            p.im = far ? t_word'($urandom) : pick_coord();
            point_queue.push_back(p);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: Mandelbrot, limit 100
        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);
        add_point(32'hE000_0000, 32'h0000_0000);
        add_point(32'h0400_0000, 32'h0000_0000);
        add_point(32'hF000_0000, 32'h0000_0000);
        add_point(32'h0000_0000, 32'h1000_0000);
        add_point(32'h0800_0000, 32'h0800_0000);
        add_point(32'hFFFF_FFFF, 32'h0000_0001);

        configure(1'b0, PRESET_RE[0], PRESET_IM[0], t_iter'(100));
        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h0000_0000);
        add_point(32'h1000_0000, 32'hF000_0000);

        configure(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, t_iter'(100));
        add_point(32'h0000_0000, 32'h0000_0000);
        add_point(32'h8000_0000, 32'h7FFF_FFFF);

        // zero limit
        configure(1'b0, PRESET_RE[2], PRESET_IM[2], t_iter'(0));
        add_point(32'h1234_5678, 32'h8000_0000);
        configure(1'b1, 32'h0000_0000, 32'h0000_0000, t_iter'(0));
        add_point(32'h7FFF_FFFF, 32'h0000_0000);

        configure(1'b1, 32'h0000_0000, 32'h0000_0000, t_iter'(1));
        add_point(32'h0800_0000, 32'h0800_0000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000);

        // top limit, escaping points only
        configure(1'b1, 32'h0000_0000, 32'h0000_0000, '1);
        add_point(32'h0800_0000, 32'h0000_0000);
        add_point(32'h1000_0000, 32'h1000_0000);
        add_point(32'h2000_0001, 32'h0000_0000);
        add_point(32'h8000_0000, 32'h8000_0000);

        configure(1'b1, t_word'($urandom), t_word'($urandom), t_iter'(100));
        queue_points(500, 1'b0);

        for (int j = 0; j < 4; j++) begin
            configure(1'b0, PRESET_RE[j], PRESET_IM[j], t_iter'(100));
            quiet = (j == 1);
            queue_points(90, 1'b0);
        end
        drain();
        quiet = 1'b0;

        configure(1'b1, t_word'($urandom), t_word'($urandom), t_iter'(20));
        queue_points(200, 1'b0);
        configure(1'b0, t_word'($urandom), t_word'($urandom), t_iter'(64));
        queue_points(200, 1'b0);
        configure(1'b0, pick_coord(), pick_coord(), t_iter'(0));
        queue_points(60, 1'b0);
        configure(1'b1, pick_coord(), pick_coord(), t_iter'(0));
        queue_points(40, 1'b0);
        configure(1'b1, pick_coord(), pick_coord(), t_iter'(1));
        queue_points(60, 1'b0);
        configure(1'b1, pick_coord(), pick_coord(), t_iter'(255));
        queue_points(100, 1'b0);
        configure(1'b1, pick_coord(), pick_coord(), '1);
        queue_points(50, 1'b1);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### escape_time_fractal_iterator_core.f
+incdir+rtl
rtl/etfi_pkg.sv
rtl/etfi_fifo.sv
rtl/etfi_front.sv
rtl/etfi_iter.sv
rtl/escape_time_fractal_iterator_core.sv
rtl/etfi_checker.sv
tb/sv/tb_escape_time_fractal_iterator_core.sv
